FILE: rtl/core/esolang_token_bracket_matcher_macros.svh
// Assertion helpers for the RTL.
`ifndef ESOLANG_TOKEN_BRACKET_MATCHER_MACROS_SVH
`define ESOLANG_TOKEN_BRACKET_MATCHER_MACROS_SVH

// Same-cycle implication, sampled on clk, held off while in reset.
`define EBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off while in reset.
`define EBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ebm_pkg.sv
`default_nettype none

package ebm_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int POSITION_BITS = 16;

  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_DW = $clog2(STACK_DEPTH + 1);

  localparam int POS_W   = 16;
  localparam int CNT_W   = POSITION_BITS + 1;
  localparam int CNT_XW  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CELL_W  = 17;
  localparam int TOKEN_W = 4;
  localparam int STAT_W  = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CELL_W-1:0] CELL_ONE    = CELL_W'(1);
  localparam logic [CELL_W-1:0] POINTER_MAX = CELL_W'(65536);

  localparam logic [TOKEN_W-1:0] CMD_END   = 4'd0;
  localparam logic [TOKEN_W-1:0] CMD_LEFT  = 4'd1;
  localparam logic [TOKEN_W-1:0] CMD_RIGHT = 4'd2;
  localparam logic [TOKEN_W-1:0] CMD_OPEN  = 4'd7;
  localparam logic [TOKEN_W-1:0] CMD_CLOSE = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BRACKET  = 2'd1;
  localparam logic [STAT_W-1:0] ST_POINTER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [POS_W-1:0] data;
  } stk_op_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] token;
    logic               token_valid;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   partner;
    logic               pair_valid;
    logic               done_res;
    logic [STAT_W-1:0]  status;
    logic [CELL_W-1:0]  pointer_extent;
  } res_t;

  // byte mod 10 via reciprocal multiply; exact for all 8-bit values
  function automatic logic [TOKEN_W-1:0] mod10(input logic [7:0] b);
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  qx10;
    prod = {8'd0, b} * 16'd205;
    q    = prod[15:11];
    qx10 = 8'({q, 3'b000}) + 8'({q, 1'b0});
    mod10 = TOKEN_W'(b - qx10);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/esolang_token_bracket_matcher.sv
// Path: a result passes the input register, then the result register; the input
// register holds its transfer while the output is stalled.
// Throughput: one transfer per cycle unless the output stalls; the open stack sits
// in a RAM with registered read, with its top entry bypassed so a close may follow
// an open. Reset: synchronous, active low; clears both registers' valids and the
// parser state. The stack RAM is not cleared. An end transfer returns to reset state.
`default_nettype none

module esolang_token_bracket_matcher
  import ebm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // byte_value
  input  wire logic                   in_tlast,   // is_end
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // token, position, partner, status,
                                                  // pointer_extent, zero pad
  output logic [OUT_TUSER_W-1:0]      out_tuser,  // token_valid, pair_valid
  output logic                        out_tlast   // done_res
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       out_vld_r;
  res_t       res_r;
  res_t       res_nxt;
  logic       step;

  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;

  ebm_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .byte_value (in_byte_r),
    .is_end     (in_end_r),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (step) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r.pointer_extent, res_r.status, res_r.partner,
                       res_r.position, res_r.token};
  assign out_tuser  = {res_r.pair_valid, res_r.token_valid};
  assign out_tlast  = res_r.done_res;

endmodule

`default_nettype wire

FILE: rtl/core/ebm_ram.sv
`default_nettype none

module ebm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/ebm_stack.sv
`default_nettype none
`include "esolang_token_bracket_matcher_macros.svh"

module ebm_stack
  import ebm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stk_op_t           op,
  output logic [STK_DW-1:0]      depth,
  output logic [POS_W-1:0]       tos
);

  logic [STK_DW-1:0] depth_r;
  logic [STK_DW-1:0] depth_nxt;
  logic              bypass_r;
  logic [POS_W-1:0]  byp_data_r;
  logic [POS_W-1:0]  rd_data;
  logic [STK_AW-1:0] raddr;
  logic [STK_AW-1:0] waddr;

  always_comb begin
    if (op.clear) begin
      depth_nxt = '0;
    end else if (op.push) begin
      depth_nxt = depth_r + STK_DW'(1);
    end else if (op.pop) begin
      depth_nxt = depth_r - STK_DW'(1);
    end else begin
      depth_nxt = depth_r;
    end
  end

  // keep the read port pointed at the top entry after this transfer
  assign raddr = STK_AW'(depth_nxt - STK_DW'(1));
  assign waddr = STK_AW'(depth_r);

  ebm_ram #(
    .WIDTH (POS_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (op.push),
    .waddr (waddr),
    .wdata (op.data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      bypass_r <= 1'b0;
    end else begin
      depth_r  <= depth_nxt;
      bypass_r <= op.push;
    end
    byp_data_r <= op.data;
  end

  // a push is read back next cycle from the bypass, not the RAM
  assign tos   = bypass_r ? byp_data_r : rd_data;
  assign depth = depth_r;

  `EBM_ASSERT_IMP(a_depth_range, 1'b1, depth_r <= STK_DW'(STACK_DEPTH), "stack depth over limit")
  `EBM_ASSERT_IMP(a_pop_nonempty, op.pop, depth_r != '0, "pop on empty stack")
  `EBM_ASSERT_IMP(a_push_room, op.push, depth_r < STK_DW'(STACK_DEPTH), "push on full stack")
  `EBM_ASSERT_NXT(a_push_grows, op.push && !op.clear, depth_r == $past(depth_r) + STK_DW'(1), "push did not grow stack")

endmodule

`default_nettype wire

FILE: rtl/core/ebm_parse.sv
`default_nettype none

module ebm_parse
  import ebm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_value,
  input  wire logic       is_end,
  output res_t            res
);

  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [CELL_W-1:0]  peak_r, peak_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STAT_W-1:0]  err_r, err_nxt;
  logic [CNT_XW-1:0]  cnt_ext;
  logic [POS_W-1:0]   pos;
  logic [TOKEN_W-1:0] cmd;
  logic               tv;
  logic               pair;
  logic               push;
  logic               pop;
  logic [STAT_W-1:0]  status;
  logic [STK_DW-1:0]  depth;
  logic [POS_W-1:0]   tos;
  stk_op_t            op;

  assign cnt_ext = CNT_XW'(cnt_r);
  assign pos     = cnt_ext[POS_W-1:0];

  always_comb begin
    cmd      = is_end ? CMD_END : mod10(byte_value);
    cell_nxt = cell_r;
    err_nxt  = err_r;
    tv       = 1'b0;
    pair     = 1'b0;
    push     = 1'b0;
    pop      = 1'b0;
    if (err_r == ST_OK) begin
      if (cnt_r[POSITION_BITS]) begin
        err_nxt = ST_OVERFLOW;
      end else begin
        unique case (cmd)
          CMD_LEFT: begin
            if (cell_r <= CELL_ONE) begin
              err_nxt = ST_POINTER;
            end else begin
              cell_nxt = cell_r - CELL_ONE;
              tv       = 1'b1;
            end
          end
          CMD_RIGHT: begin
            if (cell_r >= POINTER_MAX) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              cell_nxt = cell_r + CELL_ONE;
              tv       = 1'b1;
            end
          end
          CMD_OPEN: begin
            if (depth >= STK_DW'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              push = 1'b1;
              tv   = 1'b1;
            end
          end
          CMD_CLOSE: begin
            if (depth == '0) begin
              err_nxt = ST_BRACKET;
            end else begin
              pop  = 1'b1;
              pair = 1'b1;
              tv   = 1'b1;
            end
          end
          default: begin
            tv = 1'b1;
          end
        endcase
      end
    end
    peak_nxt = (cell_nxt > peak_r) ? cell_nxt : peak_r;
    cnt_nxt  = cnt_r[POSITION_BITS] ? cnt_r : cnt_r + CNT_W'(1);
    status   = err_nxt;
    if (is_end && (status == ST_OK) && (depth != '0)) begin
      status = ST_BRACKET;
    end
  end

  assign op.push  = step & push;
  assign op.pop   = step & pop;
  assign op.clear = step & is_end;
  assign op.data  = pos;

  ebm_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .depth (depth),
    .tos   (tos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= CELL_ONE;
      peak_r <= CELL_ONE;
      cnt_r  <= '0;
      err_r  <= ST_OK;
    end else if (step) begin
      if (is_end) begin
        cell_r <= CELL_ONE;
        peak_r <= CELL_ONE;
        cnt_r  <= '0;
        err_r  <= ST_OK;
      end else begin
        cell_r <= cell_nxt;
        peak_r <= peak_nxt;
        cnt_r  <= cnt_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  assign res.token          = tv ? cmd : '0;
  assign res.token_valid    = tv;
  assign res.position       = pos;
  assign res.partner        = pair ? tos : '0;
  assign res.pair_valid     = pair;
  assign res.done_res       = is_end;
  assign res.status         = status;
  assign res.pointer_extent = is_end ? peak_nxt : '0;

endmodule

`default_nettype wire
